### hdl/text_console_char_writer_assert.svh
// Assertion macros for the text console writer.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_WRITER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TCCW_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("text console assertion failed");

// Next-cycle implication, checked outside reset.
`define TCCW_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("text console assertion failed");

`endif

### hdl/tccw_pkg.sv
package tccw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);

  localparam int CHAR_W = 8;
  localparam int CELL_W = 16;
  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;

  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CELL_W-1:0] CELL_BLANK   = 16'h0720;
  localparam logic [CHAR_W-1:0] COLOR_RESET  = 8'd7;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_READ,
    OP_NEWLINE,
    OP_BACKSPACE,
    OP_CHAR
  } op_kind_t;

  // One classified command as it travels from the front end to the executor.
  typedef struct packed {
    op_kind_t              kind;
    logic [CHAR_W-1:0]     char_code;
    logic                  read_ok;
    logic [ADDR_W-1:0]     read_addr;
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RDWAIT,
    ST_COPY,
    ST_DRAIN,
    ST_ZERO
  } back_state_t;

  typedef struct packed {
    logic clearing;
  } back_sts_t;

endpackage

### hdl/text_console_char_writer.sv
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    command, char_code, read_col, read_row
// out_      output     out_valid / out_ready  cell_value, cursor_row, cursor_col, scrolled
// cfg_      input      cfg_we (no wait)       cfg_wdata -> text color
//
// A character, newline or backspace transaction is handled in the executor's idle state; a read
// inside the screen passes a wait state for the registered read port of the cell memory.
// A write that scrolls holds the executor while it sweeps the cell memory: one read and
// one write per moved cell, a drain state, then the bottom row is zeroed.
// After reset a clearing pass fills the screen with blanks and
// in_ready stays low; a two-entry queue lets input flow while a result waits to be taken.
`include "text_console_char_writer_assert.svh"

module text_console_char_writer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [tccw_pkg::CHAR_W-1:0]     cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_command,
  input  logic [tccw_pkg::CHAR_W-1:0]     in_char_code,
  input  logic [tccw_pkg::COL_W-1:0]      in_read_col,
  input  logic [tccw_pkg::ROW_W-1:0]      in_read_row,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tccw_pkg::CELL_W-1:0]     out_cell_value,
  output logic [tccw_pkg::ROW_W-1:0]      out_cursor_row,
  output logic [tccw_pkg::COL_W-1:0]      out_cursor_col,
  output logic                            out_scrolled
);

  tccw_pkg::back_sts_t back_sts;
  tccw_pkg::op_t       push_op, pop_op;
  logic                push_valid, push_ready;
  logic                pop_valid, pop_ready;

  // The front end takes each transaction, decodes the control characters and
  // computes the flat address of a cell read.
  tccw_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_char_code (in_char_code),
    .in_read_col  (in_read_col),
    .in_read_row  (in_read_row),
    .sts          (back_sts),
    .push_valid   (push_valid),
    .push_ready   (push_ready),
    .push_op      (push_op)
  );

  // Short command queue so the front end and the executor stall independently.
  tccw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_op     (pop_op)
  );

  // The executor owns the cell memory, the cursor and the text color. It also
  // runs the clearing pass and the scroll sweep, and holds the result register.
  tccw_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .pop_valid      (pop_valid),
    .pop_ready      (pop_ready),
    .pop_op         (pop_op),
    .sts            (back_sts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_value (out_cell_value),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col),
    .out_scrolled   (out_scrolled)
  );

  // No transaction may enter while the screen is still being cleared.
  `TCCW_ASSERT_IMP(a_no_input_while_clearing, back_sts.clearing, !in_ready)

  // Once the clearing pass is over it never starts again until the next reset.
  `TCCW_ASSERT_NXT(a_clear_runs_once, !back_sts.clearing, !back_sts.clearing)

  // A scrolled result parks the cursor at the start of the bottom row and reads no cell.
  `TCCW_ASSERT_IMP(a_scroll_parks_cursor, out_valid && out_scrolled,
                   (out_cursor_row == tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1)) &&
                   (out_cursor_col == '0) && (out_cell_value == '0))

endmodule

### hdl/tccw_front.sv
module tccw_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_command,
  input  logic [tccw_pkg::CHAR_W-1:0]         in_char_code,
  input  logic [tccw_pkg::COL_W-1:0]          in_read_col,
  input  logic [tccw_pkg::ROW_W-1:0]          in_read_row,
  input  tccw_pkg::back_sts_t                 sts,
  output logic                                push_valid,
  input  logic                                push_ready,
  output tccw_pkg::op_t                       push_op
);

  tccw_pkg::op_t op_r, op_nxt;
  logic          op_valid_r, op_valid_nxt;
  logic          in_fire;

  assign in_ready   = (!op_valid_r || push_ready) && !sts.clearing;
  assign in_fire    = in_valid && in_ready;
  assign push_valid = op_valid_r;
  assign push_op    = op_r;

  // Classify the command and work out the flat cell address of a read.
  always_comb begin
    op_nxt       = op_r;
    op_valid_nxt = op_valid_r;
    if (op_valid_r && push_ready) begin
      op_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      op_valid_nxt      = 1'b1;
      op_nxt.char_code  = in_char_code;
      op_nxt.read_ok    = (32'(in_read_col) < tccw_pkg::COLUMNS) &&
                          (32'(in_read_row) < tccw_pkg::ROWS);
      op_nxt.read_addr  = tccw_pkg::ADDR_W'(
                            tccw_pkg::ADDR_W'(in_read_row) *
                            tccw_pkg::ADDR_W'(tccw_pkg::COLUMNS) +
                            tccw_pkg::ADDR_W'(in_read_col));
      if (in_command == tccw_pkg::CMD_READ) begin
        op_nxt.kind = tccw_pkg::OP_READ;
      end else begin
        case (in_char_code)
          tccw_pkg::CH_NEWLINE:   op_nxt.kind = tccw_pkg::OP_NEWLINE;
          tccw_pkg::CH_BACKSPACE: op_nxt.kind = tccw_pkg::OP_BACKSPACE;
          default:                op_nxt.kind = tccw_pkg::OP_CHAR;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_valid_r <= 1'b0;
    end else begin
      op_valid_r <= op_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt;
  end

endmodule

### hdl/tccw_queue.sv
module tccw_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  tccw_pkg::op_t push_op,
  output logic          pop_valid,
  input  logic          pop_ready,
  output tccw_pkg::op_t pop_op
);

  tccw_pkg::op_t                   entries_r [tccw_pkg::Q_DEPTH];
  logic [tccw_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [tccw_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [tccw_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;
  logic                            do_push, do_pop;

  function automatic logic [tccw_pkg::QPTR_W-1:0] ptr_inc(
    input logic [tccw_pkg::QPTR_W-1:0] ptr
  );
    if (ptr == tccw_pkg::QPTR_W'(tccw_pkg::Q_DEPTH - 1)) begin
      return '0;
    end
    return tccw_pkg::QPTR_W'(ptr + 1'b1);
  endfunction

  assign push_ready = cnt_r != tccw_pkg::QCNT_W'(tccw_pkg::Q_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_op     = entries_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = tccw_pkg::QCNT_W'(cnt_r + 1'b1);
      2'b01:   cnt_nxt = tccw_pkg::QCNT_W'(cnt_r - 1'b1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

### hdl/tccw_back.sv
module tccw_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tccw_pkg::CHAR_W-1:0]    cfg_wdata,
  input  logic                           pop_valid,
  output logic                           pop_ready,
  input  tccw_pkg::op_t                  pop_op,
  output tccw_pkg::back_sts_t            sts,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [tccw_pkg::CELL_W-1:0]    out_cell_value,
  output logic [tccw_pkg::ROW_W-1:0]     out_cursor_row,
  output logic [tccw_pkg::COL_W-1:0]     out_cursor_col,
  output logic                           out_scrolled
);

  localparam logic [tccw_pkg::ADDR_W-1:0] LAST_ADDR =
    tccw_pkg::ADDR_W'(tccw_pkg::CELL_COUNT - 1);
  localparam logic [tccw_pkg::ADDR_W-1:0] BOTTOM_BASE =
    tccw_pkg::ADDR_W'(tccw_pkg::CELL_COUNT - tccw_pkg::COLUMNS);
  localparam logic [tccw_pkg::ADDR_W-1:0] ROW_STRIDE =
    tccw_pkg::ADDR_W'(tccw_pkg::COLUMNS);

  logic [tccw_pkg::CELL_W-1:0]  mem [tccw_pkg::CELL_COUNT];

  tccw_pkg::back_state_t        state_r, state_nxt;
  logic [tccw_pkg::ADDR_W-1:0]  cnt_r, cnt_nxt;
  logic [tccw_pkg::ROW_W-1:0]   cur_row_r, cur_row_nxt;
  logic [tccw_pkg::COL_W-1:0]   cur_col_r, cur_col_nxt;
  logic [tccw_pkg::ADDR_W-1:0]  cur_addr_r, cur_addr_nxt;
  logic [tccw_pkg::CHAR_W-1:0]  color_r;
  logic                         wr_pend_r;
  logic [tccw_pkg::ADDR_W-1:0]  wr_addr_r;
  logic [tccw_pkg::CELL_W-1:0]  rdata_r;

  logic                         out_valid_r;
  logic [tccw_pkg::CELL_W-1:0]  out_cell_r, out_cell_nxt;
  logic [tccw_pkg::ROW_W-1:0]   out_row_r;
  logic [tccw_pkg::COL_W-1:0]   out_col_r;
  logic                         out_scr_r, out_scr_nxt;
  logic                         out_load;

  logic                         mem_we;
  logic [tccw_pkg::ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [tccw_pkg::CELL_W-1:0]  mem_wdata;

  logic out_free, take, last_row, last_col, scroll_go, read_go;

  assign out_free  = !out_valid_r || out_ready;
  assign take      = (state_r == tccw_pkg::ST_IDLE) && pop_valid && out_free;
  assign last_row  = cur_row_r == tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1);
  assign last_col  = cur_col_r == tccw_pkg::COL_W'(tccw_pkg::COLUMNS - 1);
  assign scroll_go = take && last_row &&
                     ((pop_op.kind == tccw_pkg::OP_NEWLINE) ||
                      ((pop_op.kind == tccw_pkg::OP_CHAR) && last_col));
  assign read_go   = take && (pop_op.kind == tccw_pkg::OP_READ) && pop_op.read_ok;

  assign sts.clearing = state_r == tccw_pkg::ST_CLEAR;

  // Next state and sweep counter.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      tccw_pkg::ST_CLEAR: begin
        cnt_nxt = tccw_pkg::ADDR_W'(cnt_r + 1'b1);
        if (cnt_r == LAST_ADDR) begin
          state_nxt = tccw_pkg::ST_IDLE;
        end
      end
      tccw_pkg::ST_IDLE: begin
        if (read_go) begin
          state_nxt = tccw_pkg::ST_RDWAIT;
        end else if (scroll_go) begin
          state_nxt = tccw_pkg::ST_COPY;
          cnt_nxt   = ROW_STRIDE;
        end
      end
      tccw_pkg::ST_RDWAIT: state_nxt = tccw_pkg::ST_IDLE;
      tccw_pkg::ST_COPY: begin
        cnt_nxt = tccw_pkg::ADDR_W'(cnt_r + 1'b1);
        if (cnt_r == LAST_ADDR) begin
          state_nxt = tccw_pkg::ST_DRAIN;
        end
      end
      tccw_pkg::ST_DRAIN: begin
        state_nxt = tccw_pkg::ST_ZERO;
        cnt_nxt   = BOTTOM_BASE;
      end
      tccw_pkg::ST_ZERO: begin
        cnt_nxt = tccw_pkg::ADDR_W'(cnt_r + 1'b1);
        if (cnt_r == LAST_ADDR) begin
          state_nxt = tccw_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tccw_pkg::ST_IDLE;
    endcase
  end

  // Memory ports, cursor update and result loading.
  always_comb begin
    pop_ready    = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = cnt_r;
    mem_wdata    = tccw_pkg::CELL_BLANK;
    mem_raddr    = cnt_r;
    cur_row_nxt  = cur_row_r;
    cur_col_nxt  = cur_col_r;
    cur_addr_nxt = cur_addr_r;
    out_load     = 1'b0;
    out_cell_nxt = '0;
    out_scr_nxt  = 1'b0;
    case (state_r)
      tccw_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
      end
      tccw_pkg::ST_IDLE: begin
        pop_ready = out_free;
        if (take) begin
          out_load = !read_go && !scroll_go;
          case (pop_op.kind)
            tccw_pkg::OP_READ: begin
              mem_raddr = pop_op.read_addr;
            end
            tccw_pkg::OP_NEWLINE: begin
              if (!last_row) begin
                cur_row_nxt  = tccw_pkg::ROW_W'(cur_row_r + 1'b1);
                cur_col_nxt  = '0;
                cur_addr_nxt = tccw_pkg::ADDR_W'(cur_addr_r -
                                 tccw_pkg::ADDR_W'(cur_col_r) + ROW_STRIDE);
              end
            end
            tccw_pkg::OP_BACKSPACE: begin
              if (cur_col_r != '0) begin
                cur_col_nxt  = tccw_pkg::COL_W'(cur_col_r - 1'b1);
                cur_addr_nxt = tccw_pkg::ADDR_W'(cur_addr_r - 1'b1);
                mem_we       = 1'b1;
                mem_waddr    = tccw_pkg::ADDR_W'(cur_addr_r - 1'b1);
                mem_wdata    = '0;
              end
            end
            tccw_pkg::OP_CHAR: begin
              mem_we       = 1'b1;
              mem_waddr    = cur_addr_r;
              mem_wdata    = {color_r, pop_op.char_code};
              cur_addr_nxt = tccw_pkg::ADDR_W'(cur_addr_r + 1'b1);
              if (last_col) begin
                cur_col_nxt = '0;
                cur_row_nxt = tccw_pkg::ROW_W'(cur_row_r + 1'b1);
              end else begin
                cur_col_nxt = tccw_pkg::COL_W'(cur_col_r + 1'b1);
              end
            end
            default: begin
            end
          endcase
          if (scroll_go) begin
            cur_row_nxt  = tccw_pkg::ROW_W'(tccw_pkg::ROWS - 1);
            cur_col_nxt  = '0;
            cur_addr_nxt = BOTTOM_BASE;
          end
        end
      end
      tccw_pkg::ST_RDWAIT: begin
        out_load     = 1'b1;
        out_cell_nxt = rdata_r;
      end
      tccw_pkg::ST_COPY, tccw_pkg::ST_DRAIN: begin
        mem_we    = wr_pend_r;
        mem_waddr = wr_addr_r;
        mem_wdata = rdata_r;
      end
      tccw_pkg::ST_ZERO: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        if (cnt_r == LAST_ADDR) begin
          out_load    = 1'b1;
          out_scr_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tccw_pkg::ST_CLEAR;
      cnt_r       <= '0;
      cur_row_r   <= '0;
      cur_col_r   <= '0;
      cur_addr_r  <= '0;
      color_r     <= tccw_pkg::COLOR_RESET;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      cur_row_r  <= cur_row_nxt;
      cur_col_r  <= cur_col_nxt;
      cur_addr_r <= cur_addr_nxt;
      wr_pend_r  <= state_r == tccw_pkg::ST_COPY;
      if (cfg_we) begin
        color_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_addr_r <= tccw_pkg::ADDR_W'(cnt_r - ROW_STRIDE);
    if (out_load) begin
      out_cell_r <= out_cell_nxt;
      out_row_r  <= cur_row_nxt;
      out_col_r  <= cur_col_nxt;
      out_scr_r  <= out_scr_nxt;
    end
  end

  // Cell store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  assign out_valid      = out_valid_r;
  assign out_cell_value = out_cell_r;
  assign out_cursor_row = out_row_r;
  assign out_cursor_col = out_col_r;
  assign out_scrolled   = out_scr_r;

endmodule

### verif/tb_text_console_char_writer.sv
module tb_text_console_char_writer;
  timeunit 1ns;
  timeprecision 1ps;

  import tccw_pkg::*;

  // A scroll keeps the block busy while it sweeps the screen, and so does the
  // clearing pass after reset. The idle limit covers both, with a wide margin.
  localparam int IDLE_LIMIT      = 20000;
  localparam int TAIL_CYCLES     = 16;
  localparam int RAND_PHASES     = 6;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int MAX_REPORTS     = 10;

  // One result transaction as the console reports it.
  typedef struct packed {
    logic [CELL_W-1:0] cell_val;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              scrolled;
  } console_reply_t;

  // One row of the directed table. When typed is set, want holds the result
  // as it follows directly from the reset state; otherwise the shadow console
  // decides what comes back.
  typedef struct packed {
    logic              cmd;
    logic [CHAR_W-1:0] ch;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              typed;
    console_reply_t    want;
  } stim_row_t;

  localparam int DIRECTED_ROWS = 19;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    // Fresh screen: both corners read as blanks.
    '{CMD_READ,  8'hA5,        7'd0,   5'd0,  1'b1, '{16'h0720, 5'd0, 7'd0, 1'b0}},
    '{CMD_READ,  8'h5A,        7'd79,  5'd24, 1'b1, '{16'h0720, 5'd0, 7'd0, 1'b0}},
    // Reads past the right edge, below the bottom and at the field maxima.
    '{CMD_READ,  8'h00,        7'd80,  5'd0,  1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0}},
    '{CMD_READ,  8'hFF,        7'd0,   5'd25, 1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0}},
    '{CMD_READ,  8'h0A,        7'd127, 5'd31, 1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0}},
    // Backspace in column zero leaves everything alone.
    '{CMD_WRITE, CH_BACKSPACE, 7'd127, 5'd31, 1'b1, '{16'h0000, 5'd0, 7'd0, 1'b0}},
    // First character lands with the reset color.
    '{CMD_WRITE, 8'h41,        7'd0,   5'd0,  1'b1, '{16'h0000, 5'd0, 7'd1, 1'b0}},
    '{CMD_READ,  8'h00,        7'd0,   5'd0,  1'b1, '{16'h0741, 5'd0, 7'd1, 1'b0}},
    // Control bytes and the byte extremes are stored like any character.
    '{CMD_WRITE, 8'h00,        7'd55,  5'd10, 1'b0, '0},
    '{CMD_WRITE, 8'hFF,        7'd0,   5'd0,  1'b0, '0},
    '{CMD_WRITE, 8'h0D,        7'd1,   5'd1,  1'b0, '0},
    '{CMD_WRITE, CH_NEWLINE,   7'd2,   5'd2,  1'b0, '0},
    // Backspace at the start of a later row must not climb back up.
    '{CMD_WRITE, CH_BACKSPACE, 7'd3,   5'd3,  1'b0, '0},
    '{CMD_WRITE, 8'h7F,        7'd4,   5'd4,  1'b0, '0},
    '{CMD_WRITE, 8'h80,        7'd5,   5'd5,  1'b0, '0},
    '{CMD_WRITE, CH_BACKSPACE, 7'd6,   5'd6,  1'b0, '0},
    '{CMD_READ,  8'h00,        7'd1,   5'd1,  1'b0, '0},
    '{CMD_READ,  8'h00,        7'd2,   5'd0,  1'b0, '0},
    '{CMD_READ,  8'h00,        7'd3,   5'd0,  1'b0, '0}
  };

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_CHOPPY,
    RX_BLOCKED
  } rx_mode_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [CHAR_W-1:0] cfg_wdata;
  logic              in_valid;
  logic              in_ready;
  logic              in_command;
  logic [CHAR_W-1:0] in_char_code;
  logic [COL_W-1:0]  in_read_col;
  logic [ROW_W-1:0]  in_read_row;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [CELL_W-1:0] out_cell_value;
  logic [ROW_W-1:0]  out_cursor_row;
  logic [COL_W-1:0]  out_cursor_col;
  logic              out_scrolled;

  // Shadow copy of the console: cell store, cursor and text color.
  logic [CELL_W-1:0] shadow_cells [CELL_COUNT];
  int                shadow_row;
  int                shadow_col;
  logic [CHAR_W-1:0] shadow_color;

  // Results still owed by the console, oldest first.
  console_reply_t    owed_replies [$];

  int fail_count  = 0;
  int n_results   = 0;
  int n_reads     = 0;
  int n_writes    = 0;
  int n_scrolls   = 0;
  int n_wraps     = 0;
  int burst_left  = 0;
  int idle_cycles = 0;

  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;

  always #1 clk = ~clk;

  text_console_char_writer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_char_code   (in_char_code),
    .in_read_col    (in_read_col),
    .in_read_row    (in_read_row),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cell_value (out_cell_value),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col),
    .out_scrolled   (out_scrolled)
  );

  // Applies one accepted command to the shadow console and returns the result
  // that the block has to produce for it.
  function automatic console_reply_t console_apply(logic cmd, logic [CHAR_W-1:0] ch,
                                                   logic [COL_W-1:0] rd_col,
                                                   logic [ROW_W-1:0] rd_row);
    console_reply_t r;
    int             next_row;
    r = '0;
    if (cmd == CMD_READ) begin
      n_reads++;
      if (int'(rd_col) < COLUMNS && int'(rd_row) < ROWS) begin
        r.cell_val = shadow_cells[int'(rd_row) * COLUMNS + int'(rd_col)];
      end
    end else begin
      n_writes++;
      next_row = shadow_row;
      if (ch == CH_NEWLINE) begin
        next_row++;
        shadow_col = 0;
      end else if (ch == CH_BACKSPACE) begin
        // Backspace never steps back onto the previous row.
        if (shadow_col != 0) begin
          shadow_col--;
          shadow_cells[shadow_row * COLUMNS + shadow_col] = '0;
        end
      end else begin
        shadow_cells[shadow_row * COLUMNS + shadow_col] = {shadow_color, ch};
        shadow_col++;
        if (shadow_col == COLUMNS) begin
          shadow_col = 0;
          next_row++;
          n_wraps++;
        end
      end
      // Running off the bottom moves every row up and clears the last row
      // to zero cells, not to blanks.
      if (next_row >= ROWS) begin
        for (int i = 0; i < CELL_COUNT - COLUMNS; i++) begin
          shadow_cells[i] = shadow_cells[i + COLUMNS];
        end
        for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) begin
          shadow_cells[i] = '0;
        end
        next_row   = ROWS - 1;
        shadow_col = 0;
        r.scrolled = 1'b1;
        n_scrolls++;
      end
      shadow_row = next_row;
    end
    r.row = ROW_W'(shadow_row);
    r.col = COL_W'(shadow_col);
    return r;
  endfunction

  // Presents one command transaction, starting and ending at a falling edge.
  // The sender works in bursts; in_valid may drop between bursts, and some bursts
  // run long with no gap at all.
  task automatic send_command(logic cmd, logic [CHAR_W-1:0] ch, logic [COL_W-1:0] rd_col,
                              logic [ROW_W-1:0] rd_row, logic typed, console_reply_t want);
    console_reply_t predicted;
    int             gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_valid     <= 1'b1;
    in_command   <= cmd;
    in_char_code <= ch;
    in_read_col  <= rd_col;
    in_read_row  <= rd_row;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // Accepted at this edge: the shadow console moves on in the same order.
    predicted = console_apply(cmd, ch, rd_col, rd_row);
    owed_replies.push_back(typed ? want : predicted);
    burst_left--;
    @(negedge clk);
  endtask

  // Single-cycle color write; only called with nothing in flight.
  task automatic write_color(logic [CHAR_W-1:0] color);
    cfg_we    <= 1'b1;
    cfg_wdata <= color;
    @(negedge clk);
    cfg_we       <= 1'b0;
    shadow_color = color;
  endtask

  // The receiver stalls on its own pattern: open stretches, stretches where
  // ready toggles at random, and stretches held low.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_left = (rx_mode == RX_BLOCKED) ? $urandom_range(1, 30) : $urandom_range(8, 60);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_CHOPPY: out_ready <= 1'($urandom_range(0, 1));
      default:   out_ready <= 1'b0;
    endcase
  end

  // Every result transaction is checked against the oldest owed result.
  always @(posedge clk) begin
    console_reply_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (owed_replies.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("Unexpected result: cell %h row %0d col %0d scrolled %0b",
                   out_cell_value, out_cursor_row, out_cursor_col, out_scrolled);
        end
      end else begin
        want = owed_replies.pop_front();
        if (out_cell_value !== want.cell_val || out_cursor_row !== want.row ||
            out_cursor_col !== want.col || out_scrolled !== want.scrolled) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("Mismatch on result %0d: expected cell %h row %0d col %0d scrolled %0b,",
                     n_results, want.cell_val, want.row, want.col, want.scrolled);
            $display("  got cell %h row %0d col %0d scrolled %0b",
                     out_cell_value, out_cursor_row, out_cursor_col, out_scrolled);
          end
        end
      end
    end
  end

  // Watchdog: ends the run when neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles, %0d results outstanding.",
               IDLE_LIMIT, owed_replies.size());
      $display("** text_console_char_writer: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [CHAR_W-1:0] phase_color [RAND_PHASES];
    logic              cmd;
    logic [CHAR_W-1:0] ch;
    logic [COL_W-1:0]  rd_col;
    logic [ROW_W-1:0]  rd_row;
    int                pick;
    int                read_pct;
    int                newline_pct;
    int                backspace_pct;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_command   = CMD_WRITE;
    in_char_code = '0;
    in_read_col  = '0;
    in_read_row  = '0;

    for (int i = 0; i < CELL_COUNT; i++) begin
      shadow_cells[i] = CELL_BLANK;
    end
    shadow_row   = 0;
    shadow_col   = 0;
    shadow_color = COLOR_RESET;

    // Both color extremes, one per nibble, and two random ones.
    phase_color[0] = 8'h00;
    phase_color[1] = 8'hFF;
    phase_color[2] = 8'h1F;
    phase_color[3] = 8'hF0;
    phase_color[4] = CHAR_W'($urandom_range(0, 255));
    phase_color[5] = CHAR_W'($urandom_range(0, 255));

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, run with the reset color. The block may still be
    // clearing the screen; the handshake simply waits for it.
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      send_command(DIRECTED[i].cmd, DIRECTED[i].ch, DIRECTED[i].col, DIRECTED[i].row,
                   DIRECTED[i].typed, DIRECTED[i].want);
    end

    // Random part in phases. Each phase drains, switches the color and then
    // either fills long lines (wraps, with scrolls once at the bottom) or
    // leans on newlines, which keep the screen scrolling.
    for (int p = 0; p < RAND_PHASES; p++) begin
      in_valid <= 1'b0;
      while (owed_replies.size() != 0) @(negedge clk);
      write_color(phase_color[p]);
      if (p % 2 == 0) begin
        read_pct      = 20;
        newline_pct   = 0;
        backspace_pct = 6;
      end else begin
        read_pct      = 25;
        newline_pct   = 30;
        backspace_pct = 10;
      end
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        pick   = $urandom_range(0, 99);
        cmd    = CMD_WRITE;
        ch     = CHAR_W'($urandom_range(0, 255));
        rd_col = COL_W'($urandom_range(0, 127));
        rd_row = ROW_W'($urandom_range(0, 31));
        if (pick < read_pct) begin
          cmd = CMD_READ;
          case ($urandom_range(0, 5))
            0: ;
            1, 2: begin
              // Look at the cell just behind the cursor, where the latest character
              // landed if no newline or backspace came after it.
              rd_row = ROW_W'(shadow_row);
              rd_col = COL_W'((shadow_col == 0) ? 0 : shadow_col - 1);
            end
            default: begin
              rd_row = ROW_W'($urandom_range(0, ROWS - 1));
              rd_col = COL_W'($urandom_range(0, COLUMNS - 1));
            end
          endcase
        end else if (pick < read_pct + newline_pct) begin
          ch = CH_NEWLINE;
        end else if (pick < read_pct + newline_pct + backspace_pct) begin
          ch = CH_BACKSPACE;
        end
        send_command(cmd, ch, rd_col, rd_row, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d write commands and %0d cell reads, with %0d scrolls and %0d wraps,",
             n_writes, n_reads, n_scrolls, n_wraps);
    $display("under %0d text colors; %0d results checked, %0d failures.",
             RAND_PHASES + 1, n_results, fail_count);
    if (fail_count == 0 && owed_replies.size() == 0) begin
      $display("** text_console_char_writer: PASSED **");
    end else begin
      $display("** text_console_char_writer: FAILED **");
    end
    $finish;
  end

endmodule
